>>> rtl/fsic_pkg.sv
`default_nettype none

package fsic_pkg;

    // build-time defaults and sizes
    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 8;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_W            = $clog2(QUEUE_DEPTH + 1);

    // statistics reset values
    localparam logic signed [33:0] MIN_RESET     = 34'sh0_0001_0000;
    localparam logic signed [33:0] MIN_RESTART8  = 34'sh0_0000_0100;
    localparam logic signed [33:0] MIN_RESTART16 = 34'sh0_0001_0000;
    localparam logic signed [33:0] MIN_RESTART32 = 34'sh1_0000_0000;

    // configuration reset values
    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
    localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;
    localparam logic [1:0]  WIDTH_RESET  = 2'd1;

    // quiet nan pattern
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    // register indexes
    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_OFFSET = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_SIGNED = 2'd3
    } reg_index_t;

    // output width codes, anything else means thirty-two bits
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    typedef struct packed {
        logic [31:0] scale_bits;
        logic [31:0] offset_bits;
        logic [1:0]  width_mode;
        logic        signed_out;
    } cfg_t;

    // unpacked binary32: value = mant * 2^(exp-23), mant normalised
    typedef struct packed {
        logic              sign;
        logic signed [9:0] exp;
        logic [23:0]       mant;
        logic              is_zero;
        logic              is_inf;
        logic              is_nan;
    } fp_t;

    // converted transaction between front and back
    typedef struct packed {
        logic signed [33:0] val;
        logic               overflow;
        logic               underflow;
        logic               restart;
    } conv_t;

    // leading zero count, 32 when the word is zero
    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // split a binary32, subnormals normalised
    function automatic fp_t fp_unpack(input logic [31:0] b);
        fp_t        r;
        logic [5:0] lz;
        r.sign    = b[31];
        r.exp     = '0;
        r.mant    = '0;
        r.is_zero = 1'b0;
        r.is_inf  = 1'b0;
        r.is_nan  = 1'b0;
        lz        = lzc32({1'b0, b[22:0], 8'hFF});
        if (b[30:23] == 8'hFF) begin
            r.is_inf = (b[22:0] == 23'd0);
            r.is_nan = (b[22:0] != 23'd0);
        end
        else if (b[30:23] == 8'd0) begin
            if (b[22:0] == 23'd0) begin
                r.is_zero = 1'b1;
            end
            else begin
                r.mant = {1'b0, b[22:0]} << lz;
                r.exp  = -10'sd126 - $signed({4'd0, lz});
            end
        end
        else begin
            r.mant = {1'b1, b[22:0]};
            r.exp  = $signed({2'd0, b[30:23]}) - 10'sd127;
        end
        return r;
    endfunction

    // round to nearest even and pack; mn has its top bit set, value = mn * 2^(e-47)
    function automatic logic [31:0] round_pack(input logic sign, input logic signed [9:0] e,
                                               input logic [47:0] mn);
        logic [95:0] wide;
        logic [9:0]  sh;
        logic [23:0] keep;
        logic        g;
        logic        st;
        logic        inc;
        logic [7:0]  expf;
        logic [30:0] mag;
        wide = {mn, 48'd0};
        sh   = '0;
        expf = '0;
        if (e > 10'sd127) begin
            return {sign, 8'hFF, 23'd0};
        end
        if (e >= -10'sd126) begin
            expf = 8'(e + 10'sd127);
        end
        else begin
            sh = 10'(-10'sd126 - e);
            if (sh > 10'd50) begin
                sh = 10'd50;
            end
            wide = {mn, 48'd0} >> sh;
        end
        keep = wide[95:72];
        g    = wide[71];
        st   = |wide[70:0];
        inc  = g & (st | keep[0]);
        mag  = {expf, keep[22:0]} + {30'd0, inc};
        return {sign, mag};
    endfunction

    // ceil(v - 0.5) with saturation into the chosen integer type
    function automatic conv_t convert(input logic [31:0] v, input logic [1:0] wm,
                                      input logic sgn);
        logic [7:0]         ef;
        logic [22:0]        f;
        logic               nan;
        logic               big;
        logic [5:0]         sh;
        logic [57:0]        fx;
        logic [33:0]        mag;
        logic [5:0]         w;
        logic signed [34:0] r;
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        logic signed [34:0] val;
        conv_t              c;
        ef  = v[30:23];
        f   = v[22:0];
        r   = '0;
        sh  = '0;
        fx  = '0;
        mag = '0;
        case (wm)
            WIDTH_8:  w = 6'd8;
            WIDTH_16: w = 6'd16;
            default:  w = 6'd32;
        endcase
        if (sgn) begin
            hi = $signed((35'd1 << (w - 6'd1)) - 35'd1);
            lo = -hi - 35'sd1;
        end
        else begin
            hi = $signed((35'd1 << w) - 35'd1);
            lo = '0;
        end
        nan = (ef == 8'hFF) && (f != 23'd0);
        big = (ef == 8'hFF) || (ef > 8'd159) || ((ef == 8'd159) && (f != 23'd0));
        // below a quarter the result is zero
        if (!big && (ef >= 8'd125)) begin
            sh  = 6'(ef - 8'd125);
            fx  = {34'd0, 1'b1, f} << sh;
            mag = {1'b0, fx[57:25]}
                + {33'd0, (v[31] ? fx[24] : (fx[24] & (|fx[23:0])))};
            r   = v[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        c.restart = 1'b0;
        if (nan) begin
            c.overflow  = 1'b1;
            c.underflow = 1'b0;
            val         = '0;
        end
        else if (big) begin
            c.overflow  = !v[31];
            c.underflow = v[31];
            val         = v[31] ? lo : hi;
        end
        else begin
            c.overflow  = (r > hi);
            c.underflow = (r < lo);
            val         = c.overflow ? hi : (c.underflow ? lo : r);
        end
        c.val = val[33:0];
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fsic_front.sv
`default_nettype none

module fsic_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [31:0]    sample_bits,
    input  wire logic           restart_stats,
    input  wire fsic_pkg::cfg_t cfg,
    input  wire logic           pop,
    output logic                push,
    output fsic_pkg::conv_t     push_data
);

    logic accept;

    // control registers
    logic [fsic_pkg::CREDIT_W-1:0] credit_reg, credit_next;
    logic [5:0] valid_reg, valid_next;

    // stage 1: unpacked operands
    logic [23:0]       ma_reg, ma_next, mb_reg, mb_next;
    logic signed [9:0] esum1_reg, esum1_next;
    logic              sgn1_reg, sgn1_next, nan1_reg, nan1_next;
    logic              inf1_reg, inf1_next, zero1_reg, zero1_next;
    logic [4:0]        rst_reg, rst_next;

    // stage 2: product
    logic [47:0]       prod_reg, prod_next;
    logic signed [9:0] esum2_reg, esum2_next;
    logic              sgn2_reg, sgn2_next, nan2_reg, nan2_next;
    logic              inf2_reg, inf2_next, zero2_reg, zero2_next;

    // stage 3: rounded product
    logic [31:0] p_reg, p_next;

    // stage 4: aligned sum
    logic              direct_reg, direct_next;
    logic [31:0]       dbits_reg, dbits_next;
    logic [27:0]       sum_reg, sum_next;
    logic signed [9:0] ebig_reg, ebig_next;
    logic              sgn4_reg, sgn4_next;

    // stage 5: rounded sum
    logic [31:0] v_reg, v_next;

    // stage 6: converted result
    fsic_pkg::conv_t conv_reg, conv_next;

    assign in_stall = (credit_reg == fsic_pkg::CREDIT_W'(fsic_pkg::QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign push      = valid_reg[5];
    assign push_data = conv_reg;

    // credits cover every transaction in the pipeline and the queue
    always_comb
    begin
        credit_next = credit_reg + fsic_pkg::CREDIT_W'(accept) - fsic_pkg::CREDIT_W'(pop);
        valid_next  = {valid_reg[4:0], accept};
        rst_next    = {rst_reg[3:0], restart_stats};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            valid_reg  <= valid_next;
        end
    end

    // unpack sample and scale
    always_comb
    begin
        fsic_pkg::fp_t xu;
        fsic_pkg::fp_t su;
        xu = fsic_pkg::fp_unpack(sample_bits);
        su = fsic_pkg::fp_unpack(cfg.scale_bits);
        ma_next    = xu.mant;
        mb_next    = su.mant;
        esum1_next = xu.exp + su.exp;
        sgn1_next  = xu.sign ^ su.sign;
        nan1_next  = xu.is_nan || su.is_nan || (xu.is_inf && su.is_zero)
                   || (xu.is_zero && su.is_inf);
        inf1_next  = xu.is_inf || su.is_inf;
        zero1_next = xu.is_zero || su.is_zero;
    end

    // mantissa multiply
    always_comb
    begin
        prod_next  = ma_reg * mb_reg;
        esum2_next = esum1_reg;
        sgn2_next  = sgn1_reg;
        nan2_next  = nan1_reg;
        inf2_next  = inf1_reg;
        zero2_next = zero1_reg;
    end

    // normalise and round the product
    always_comb
    begin
        logic [47:0]       mn;
        logic signed [9:0] e;
        mn = prod_reg[47] ? prod_reg : {prod_reg[46:0], 1'b0};
        e  = prod_reg[47] ? esum2_reg + 10'sd1 : esum2_reg;
        if (nan2_reg)
            p_next = fsic_pkg::QNAN_BITS;
        else if (inf2_reg)
            p_next = {sgn2_reg, 8'hFF, 23'd0};
        else if (zero2_reg)
            p_next = {sgn2_reg, 31'd0};
        else
            p_next = fsic_pkg::round_pack(sgn2_reg, e, mn);
    end

    // classify the add and align the smaller operand
    always_comb
    begin
        fsic_pkg::fp_t pu;
        fsic_pkg::fp_t ou;
        fsic_pkg::fp_t bg;
        fsic_pkg::fp_t sm;
        logic          p_big;
        logic [9:0]    d;
        logic [53:0]   wide;
        logic [26:0]   big27;
        logic [26:0]   small27;
        pu = fsic_pkg::fp_unpack(p_reg);
        ou = fsic_pkg::fp_unpack(cfg.offset_bits);
        direct_next = 1'b1;
        dbits_next  = '0;
        if (pu.is_nan || ou.is_nan || (pu.is_inf && ou.is_inf && (pu.sign != ou.sign)))
            dbits_next = fsic_pkg::QNAN_BITS;
        else if (pu.is_inf)
            dbits_next = p_reg;
        else if (ou.is_inf)
            dbits_next = cfg.offset_bits;
        else if (pu.is_zero && ou.is_zero)
            dbits_next = {pu.sign & ou.sign, 31'd0};
        else if (pu.is_zero)
            dbits_next = cfg.offset_bits;
        else if (ou.is_zero)
            dbits_next = p_reg;
        else
            direct_next = 1'b0;
        p_big = (pu.exp > ou.exp) || ((pu.exp == ou.exp) && (pu.mant >= ou.mant));
        bg    = p_big ? pu : ou;
        sm    = p_big ? ou : pu;
        d     = 10'(bg.exp - sm.exp);
        if (d > 10'd30)
            d = 10'd30;
        wide    = {sm.mant, 3'b000, 27'd0} >> d;
        small27 = wide[53:27] | {26'd0, (|wide[26:0])};
        big27   = {bg.mant, 3'b000};
        if (bg.sign != sm.sign)
            sum_next = {1'b0, big27} - {1'b0, small27};
        else
            sum_next = {1'b0, big27} + {1'b0, small27};
        ebig_next = bg.exp;
        sgn4_next = bg.sign;
    end

    // normalise and round the sum
    always_comb
    begin
        logic [5:0]        lz;
        logic [26:0]       n27;
        logic signed [9:0] e;
        lz  = fsic_pkg::lzc32({sum_reg[26:0], 5'b11111});
        n27 = sum_reg[26:0] << lz;
        e   = ebig_reg - $signed({4'd0, lz});
        if (sum_reg[27])
        begin
            n27 = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            e   = ebig_reg + 10'sd1;
        end
        if (direct_reg)
            v_next = dbits_reg;
        else if (sum_reg == 28'd0)
            v_next = 32'd0;
        else
            v_next = fsic_pkg::round_pack(sgn4_reg, e, {n27, 21'd0});
    end

    // integer conversion
    always_comb
    begin
        conv_next         = fsic_pkg::convert(v_reg, cfg.width_mode, cfg.signed_out);
        conv_next.restart = rst_reg[4];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        esum1_reg  <= esum1_next;
        sgn1_reg   <= sgn1_next;
        nan1_reg   <= nan1_next;
        inf1_reg   <= inf1_next;
        zero1_reg  <= zero1_next;
        rst_reg    <= rst_next;
        prod_reg   <= prod_next;
        esum2_reg  <= esum2_next;
        sgn2_reg   <= sgn2_next;
        nan2_reg   <= nan2_next;
        inf2_reg   <= inf2_next;
        zero2_reg  <= zero2_next;
        p_reg      <= p_next;
        direct_reg <= direct_next;
        dbits_reg  <= dbits_next;
        sum_reg    <= sum_next;
        ebig_reg   <= ebig_next;
        sgn4_reg   <= sgn4_next;
        v_reg      <= v_next;
        conv_reg   <= conv_next;
    end

endmodule

`default_nettype wire

>>> rtl/fsic_queue.sv
`default_nettype none

module fsic_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fsic_pkg::conv_t push_data,
    input  wire logic            pop,
    output logic                 empty,
    output fsic_pkg::conv_t      head
);

    fsic_pkg::conv_t entry_reg [fsic_pkg::QUEUE_DEPTH];
    logic [fsic_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [fsic_pkg::CREDIT_W-1:0] fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + fsic_pkg::CREDIT_W'(push) - fsic_pkg::CREDIT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry write
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> rtl/fsic_back.sv
`default_nettype none

module fsic_back #(
    parameter int COUNT_WIDTH = fsic_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [1:0]      width_mode,
    input  wire logic            empty,
    input  wire fsic_pkg::conv_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [31:0]          value_bits,
    output logic                 overflow,
    output logic                 underflow,
    output logic [33:0]          running_max,
    output logic [33:0]          running_min,
    output logic [31:0]          overflow_total,
    output logic [31:0]          underflow_total
);

    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            value_reg, value_next;
    logic                   ovf_reg, ovf_next, unf_reg, unf_next;
    logic signed [33:0]     max_reg, max_next, min_reg, min_next;
    logic [COUNT_WIDTH-1:0] over_reg, over_next, under_reg, under_next;
    logic [COUNT_WIDTH+31:0] over_ext, under_ext;

    // take the next transaction once the output register is free
    assign pop = !empty && (!out_valid_reg || !out_stall);

    // statistics update, restart applied first
    always_comb
    begin
        logic signed [33:0]     base_max;
        logic signed [33:0]     base_min;
        logic signed [33:0]     restart_min;
        logic [COUNT_WIDTH-1:0] base_over;
        logic [COUNT_WIDTH-1:0] base_under;
        case (width_mode)
            fsic_pkg::WIDTH_8:  restart_min = fsic_pkg::MIN_RESTART8;
            fsic_pkg::WIDTH_16: restart_min = fsic_pkg::MIN_RESTART16;
            default:            restart_min = fsic_pkg::MIN_RESTART32;
        endcase
        base_max   = head.restart ? '0 : max_reg;
        base_min   = head.restart ? restart_min : min_reg;
        base_over  = head.restart ? '0 : over_reg;
        base_under = head.restart ? '0 : under_reg;
        max_next   = (head.val > base_max) ? head.val : base_max;
        min_next   = (head.val < base_min) ? head.val : base_min;
        over_next  = (head.overflow && (base_over != '1)) ? base_over + 1'b1 : base_over;
        under_next = (head.underflow && (base_under != '1)) ? base_under + 1'b1 : base_under;
        case (width_mode)
            fsic_pkg::WIDTH_8:  value_next = {24'd0, head.val[7:0]};
            fsic_pkg::WIDTH_16: value_next = {16'd0, head.val[15:0]};
            default:            value_next = head.val[31:0];
        endcase
        ovf_next       = head.overflow;
        unf_next       = head.underflow;
        out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            min_reg       <= fsic_pkg::MIN_RESET;
            over_reg      <= '0;
            under_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                max_reg   <= max_next;
                min_reg   <= min_next;
                over_reg  <= over_next;
                under_reg <= under_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
            unf_reg   <= unf_next;
        end
    end

    // low 32 bits of the counts
    assign over_ext  = {32'd0, over_reg};
    assign under_ext = {32'd0, under_reg};

    assign out_valid       = out_valid_reg;
    assign value_bits      = value_reg;
    assign overflow        = ovf_reg;
    assign underflow       = unf_reg;
    assign running_max     = max_reg;
    assign running_min     = min_reg;
    assign overflow_total  = over_ext[31:0];
    assign underflow_total = under_ext[31:0];

endmodule

`default_nettype wire

>>> rtl/float_scale_to_int_convert_core.sv
// path: a result passes six arithmetic stages, the first loaded at acceptance, then one
//   queue slot and the output register
// throughput: one transaction per cycle; the eight-entry queue credit sets in_stall
// reset: rst_n is asynchronous, active low; it restores the register defaults
//   (scale 1.0, offset 0.0, 16-bit unsigned) and clears the statistics
`default_nettype none

module float_scale_to_int_convert_core #(
    parameter int COUNT_WIDTH = fsic_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] sample_bits,
    input  wire logic        restart_stats,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value_bits,
    output logic             overflow,
    output logic             underflow,
    output logic [33:0]      running_max,
    output logic [33:0]      running_min,
    output logic [31:0]      overflow_total,
    output logic [31:0]      underflow_total
);

    fsic_pkg::cfg_t  cfg_reg, cfg_next;
    fsic_pkg::conv_t push_data, head;
    logic            push, pop, empty;

    // configuration write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (fsic_pkg::reg_index_t'(cfg_index))
                fsic_pkg::REG_SCALE:  cfg_next.scale_bits  = cfg_data;
                fsic_pkg::REG_OFFSET: cfg_next.offset_bits = cfg_data;
                fsic_pkg::REG_WIDTH:  cfg_next.width_mode  = cfg_data[1:0];
                fsic_pkg::REG_SIGNED: cfg_next.signed_out  = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_bits  <= fsic_pkg::SCALE_RESET;
            cfg_reg.offset_bits <= fsic_pkg::OFFSET_RESET;
            cfg_reg.width_mode  <= fsic_pkg::WIDTH_RESET;
            cfg_reg.signed_out  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // arithmetic front end
    fsic_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_bits   (sample_bits),
        .restart_stats (restart_stats),
        .cfg           (cfg_reg),
        .pop           (pop),
        .push          (push),
        .push_data     (push_data)
    );

    // decoupling queue
    fsic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    // statistics and output register
    fsic_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .width_mode      (cfg_reg.width_mode),
        .empty           (empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .value_bits      (value_bits),
        .overflow        (overflow),
        .underflow       (underflow),
        .running_max     (running_max),
        .running_min     (running_min),
        .overflow_total  (overflow_total),
        .underflow_total (underflow_total)
    );

endmodule

`default_nettype wire

>>> rtl/fsic_checker.sv
`default_nettype none

module fsic_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] value_bits,
    input wire logic        overflow,
    input wire logic        underflow,
    input wire logic [33:0] running_max,
    input wire logic [33:0] running_min
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its value
    a_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(value_bits))
        else $error("result value changed while stalled");

    // saturation goes one way only
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && underflow))
        else $error("overflow and underflow together");

    // every result has been folded into both extremes
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(running_min) <= $signed(running_max)))
        else $error("running minimum above running maximum");

endmodule

bind float_scale_to_int_convert_core fsic_checker u_fsic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value_bits  (value_bits),
    .overflow    (overflow),
    .underflow   (underflow),
    .running_max (running_max),
    .running_min (running_min)
);

`default_nettype wire

>>> sim/float_scale_to_int_convert_checker.sv
`default_nettype none

module float_scale_to_int_convert_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] sample_bits,
    input  wire logic        restart_stats,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] value_bits,
    input  wire logic        overflow,
    input  wire logic        underflow,
    input  wire logic [33:0] running_max,
    input  wire logic [33:0] running_min,
    input  wire logic [31:0] overflow_total,
    input  wire logic [31:0] underflow_total,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
        logic        unf;
        logic [33:0] maxv;
        logic [33:0] minv;
        logic [31:0] ovf_total;
        logic [31:0] unf_total;
    } conv_result_t;

    // shadow of the configuration and statistics
    logic [31:0]  scale_q;
    logic [31:0]  offset_q;
    logic [1:0]   width_q;
    logic         signed_q;
    longint       max_q;
    longint       min_q;
    logic [31:0]  ovf_cnt;
    logic [31:0]  unf_cnt;
    conv_result_t pending_results[$];

    assign outstanding = pending_results.size();

    function automatic int width_bits(input logic [1:0] wm);
        if (wm == fsic_pkg::WIDTH_8) return 8;
        if (wm == fsic_pkg::WIDTH_16) return 16;
        return 32;
    endfunction

    // binary32 pattern to a real, subnormals normalised by hand
    function automatic real single_to_real(input logic [31:0] b);
        logic [63:0] d;
        logic [23:0] m;
        int          e;
        d = '0;
        d[63] = b[31];
        if (b[30:23] == 8'hFF) begin
            d[62:52] = 11'h7FF;
            d[51:29] = b[22:0];
        end
        else if (b[30:23] == 8'd0) begin
            if (b[22:0] != 23'd0) begin
                m = {1'b0, b[22:0]};
                e = -126;
                while (!m[23]) begin
                    m = m << 1;
                    e = e - 1;
                end
                d[62:52] = 11'(e + 1023);
                d[51:29] = m[22:0];
            end
        end
        else begin
            d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
            d[51:29] = b[22:0];
        end
        return $bitstoreal(d);
    endfunction

    // narrow a real to binary32, round to nearest even
    function automatic logic [31:0] real_to_single(input real x);
        logic [63:0]  d;
        logic [52:0]  m;
        logic [52:0]  rest;
        logic [23:0]  kept;
        logic [30:0]  mag;
        int           e;
        int           sh;
        logic         g;
        logic         st;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 52'd0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
        end
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        e = int'(d[62:52]) - 1023;
        if (e > 127) begin
            return {d[63], 8'hFF, 23'd0};
        end
        // below half of the smallest subnormal step everything rounds to zero
        if (e < -150) begin
            return {d[63], 31'd0};
        end
        m  = {1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 55) sh = 55;
        kept = 24'(m >> sh);
        rest = m & ((53'd1 << sh) - 53'd1);
        g    = rest[sh-1];
        st   = (rest & ((53'd1 << (sh - 1)) - 53'd1)) != 53'd0;
        if (e >= -126) mag = {8'(e + 127), kept[22:0]};
        else mag = {8'd0, kept[22:0]};
        mag = mag + 31'(g & (st | kept[0]));
        return {d[63], mag};
    endfunction

    // compare every delivered result and predict on every accepted transaction
    always @(posedge clk or negedge rst_n) begin
        conv_result_t got;
        conv_result_t want;
        logic [31:0]  prod;
        logic [31:0]  sum;
        real          vr;
        real          dr;
        longint       hi;
        longint       lo;
        longint       rv;
        longint       val;
        longint       mx;
        longint       mn;
        int           w;
        logic         nan;
        logic         ovf;
        logic         unf;
        if (!rst_n) begin
            scale_q  <= fsic_pkg::SCALE_RESET;
            offset_q <= fsic_pkg::OFFSET_RESET;
            width_q  <= fsic_pkg::WIDTH_RESET;
            signed_q <= 1'b0;
            max_q    <= 0;
            min_q    <= 64'd1 << 16;
            ovf_cnt  <= '0;
            unf_cnt  <= '0;
            mismatches = 0;
            pending_results.delete();
        end
        else begin
            // result side
            if (out_valid && !out_stall) begin
                got = '{value_bits, overflow, underflow, running_max, running_min,
                        overflow_total, underflow_total};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value %h", value_bits);
                end
                else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp val %h ovf %b unf %b max %h min %h oc %0d uc %0d",
                                     want.value, want.ovf, want.unf, want.maxv, want.minv,
                                     want.ovf_total, want.unf_total);
                            $display("         got val %h ovf %b unf %b max %h min %h oc %0d uc %0d",
                                     got.value, got.ovf, got.unf, got.maxv, got.minv,
                                     got.ovf_total, got.unf_total);
                        end
                    end
                end
            end
            // register writes
            if (cfg_we) begin
                case (fsic_pkg::reg_index_t'(cfg_index))
                    fsic_pkg::REG_SCALE:  scale_q  <= cfg_data;
                    fsic_pkg::REG_OFFSET: offset_q <= cfg_data;
                    fsic_pkg::REG_WIDTH:  width_q  <= cfg_data[1:0];
                    fsic_pkg::REG_SIGNED: signed_q <= cfg_data[0];
                    default: ;
                endcase
            end
            // input side
            if (in_valid && !in_stall) begin
                w  = width_bits(width_q);
                mx = max_q;
                mn = min_q;
                want.ovf_total = ovf_cnt;
                want.unf_total = unf_cnt;
                if (restart_stats) begin
                    mx = 0;
                    mn = 64'd1 << w;
                    want.ovf_total = '0;
                    want.unf_total = '0;
                end
                if (signed_q) begin
                    hi = (64'd1 << (w - 1)) - 1;
                    lo = -hi - 1;
                end
                else begin
                    hi = (64'd1 << w) - 1;
                    lo = 0;
                end
                prod = real_to_single(single_to_real(scale_q) * single_to_real(sample_bits));
                sum  = real_to_single(single_to_real(prod) + single_to_real(offset_q));
                nan  = (sum[30:23] == 8'hFF) && (sum[22:0] != 23'd0);
                ovf  = 1'b0;
                unf  = 1'b0;
                rv   = 0;
                vr   = single_to_real(sum);
                if (nan) ;
                else if (vr > 4294967296.0) ovf = 1'b1;
                else if (vr < -4294967296.0) unf = 1'b1;
                else begin
                    // ceiling of v - 0.5 from a nearest integer
                    dr = vr - 0.5;
                    rv = longint'(dr);
                    if (real'(rv) < dr) rv = rv + 1;
                    if (rv > hi) ovf = 1'b1;
                    else if (rv < lo) unf = 1'b1;
                end
                if (nan) begin
                    val = 0;
                    ovf = 1'b1;
                end
                else if (ovf) val = hi;
                else if (unf) val = lo;
                else val = rv;
                if (ovf && want.ovf_total != 32'hFFFF_FFFF) want.ovf_total++;
                if (unf && want.unf_total != 32'hFFFF_FFFF) want.unf_total++;
                if (val > mx) mx = val;
                if (val < mn) mn = val;
                want.value = (w == 32) ? 32'(val) : 32'(val & ((64'd1 << w) - 1));
                want.ovf   = ovf;
                want.unf   = unf;
                want.maxv  = 34'(mx);
                want.minv  = 34'(mn);
                max_q   <= mx;
                min_q   <= mn;
                ovf_cnt <= want.ovf_total;
                unf_cnt <= want.unf_total;
                pending_results.push_back(want);
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/float_scale_to_int_convert_core_tb.sv
`default_nettype none

module float_scale_to_int_convert_core_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] sample_bits;
    logic        restart_stats;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value_bits;
    logic        overflow;
    logic        underflow;
    logic [33:0] running_max;
    logic [33:0] running_min;
    logic [31:0] overflow_total;
    logic [31:0] underflow_total;
    int          mismatches;
    int          outstanding;
    int          send_idle_pct;
    int          stall_pct;

    float_scale_to_int_convert_core u_top (.*);

    float_scale_to_int_convert_checker u_checker (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // run time limit
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    // one transaction with a random sender gap in front
    task automatic send_sample(input logic [31:0] bits, input logic restart);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample_bits   <= bits;
        restart_stats <= restart;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input fsic_pkg::reg_index_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] scl, input logic [31:0] off,
                              input logic [1:0] wm, input logic sgn);
        write_reg(fsic_pkg::REG_SCALE, scl);
        write_reg(fsic_pkg::REG_OFFSET, off);
        write_reg(fsic_pkg::REG_WIDTH, {30'd0, wm});
        write_reg(fsic_pkg::REG_SIGNED, {31'd0, sgn});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // samples biased towards the interesting conversion range
    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        int          e;
        case ($urandom_range(0, 9))
            0, 1: b = $urandom;
            2: begin
                case ($urandom_range(0, 5))
                    0: b = 32'h7F80_0000;
                    1: b = 32'hFF80_0000;
                    2: b = 32'h7FC0_0000 | $urandom_range(0, 255);
                    3: b = {$urandom_range(0, 1) == 1, 31'd0};
                    4: b = {1'b0, 8'd0, 23'($urandom)};
                    default: b = {1'b1, 8'd0, 23'($urandom)};
                endcase
            end
            3, 4: begin
                // whole multiples of one half
                e = $urandom_range(126, 149);
                b = {1'($urandom), 8'(e), 23'($urandom)};
                b[22:0] = b[22:0] & ~23'((32'd1 << (149 - e)) - 1);
            end
            default: b = {1'($urandom), 8'($urandom_range(118, 160)), 23'($urandom)};
        endcase
        return b;
    endfunction

    initial
    begin
        int          phase;
        logic [31:0] scl;
        logic [31:0] off;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_bits   = '0;
        restart_stats = 1'b0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset configuration, halves, extremes and specials
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h3F00_0000, 1'b0);    // 0.5
        send_sample(32'h3FC0_0000, 1'b0);    // 1.5
        send_sample(32'h4020_0000, 1'b0);    // 2.5
        send_sample(32'hBF00_0000, 1'b0);    // -0.5
        send_sample(32'h477F_FF00, 1'b0);    // 65535
        send_sample(32'h4780_0000, 1'b0);    // 65536
        send_sample(32'h7F80_0000, 1'b0);    // +inf
        send_sample(32'hFF80_0000, 1'b0);    // -inf
        send_sample(32'h7FC0_0000, 1'b0);    // nan
        send_sample(32'hFFFF_FFFF, 1'b1);    // nan with restart
        send_sample(32'h0000_0001, 1'b0);    // subnormal
        send_sample(32'h4F80_0000, 1'b0);    // 2^32
        send_sample(32'h4F80_0001, 1'b0);
        send_sample(32'hCF80_0000, 1'b0);
        send_sample(32'h7F7F_FFFF, 1'b1);
        drain();
        set_config(32'h3F80_0000, 32'h0000_0000, 2'd3, 1'b1);
        send_sample(32'h4F00_0000, 1'b0);    // 2^31
        send_sample(32'hCF00_0000, 1'b0);    // -2^31
        send_sample(32'h4EFF_FFFF, 1'b0);
        send_sample(32'hBFC0_0000, 1'b1);    // -1.5
        drain();
        set_config(32'h4000_0000, 32'hBF00_0000, 2'd0, 1'b0);
        send_sample(32'h4300_0000, 1'b0);    // 128 -> 255.5
        send_sample(32'h437F_0000, 1'b0);
        send_sample(32'hBE80_0000, 1'b0);
        send_sample(32'h42FE_0000, 1'b0);

        // random phases with varied configuration and idling
        for (phase = 0; phase < 8; phase++) begin
            drain();
            scl = {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
            off = {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
            case (phase)
                0: set_config(32'h3F80_0000, 32'h0000_0000, 2'd0, 1'b1);
                1: set_config(32'hFFFF_FFFF, 32'h0000_0000, 2'd2, 1'b0);
                2: set_config(32'h0000_0000, 32'hFFFF_FFFF, 2'd1, 1'b1);
                3: set_config(32'h7F7F_FFFF, 32'h8000_0001, 2'd3, 1'b0);
                default: set_config(scl, off, 2'($urandom_range(0, 3)), 1'($urandom));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int i = 0; i < 160; i++) begin
                if (phase == 5 && i == 80) begin
                    // let every result come back before going on
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (outstanding != 0) @(posedge clk);
                end
                send_sample(random_sample(), $urandom_range(0, 19) == 0);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
